// ===== rtl/core/servo_instruction_packet_framer_unit_defines.svh =====
// Assertion macros used by the servo instruction packet framer checker svpf_checker.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_UNIT_DEFINES_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define SVPF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that an expression never holds outside of reset.
`define SVPF_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/core/svpf_pkg.sv =====
// Shared types and constants of the servo instruction packet framer.
// Used by the controller, the datapath and the top level; depends on nothing.
package svpf_pkg;

   localparam logic [7:0] OP_PING      = 8'd1;
   localparam logic [7:0] OP_READ      = 8'd2;
   localparam logic [7:0] OP_WRITE     = 8'd3;
   localparam logic [7:0] OP_REG_WRITE = 8'd4;
   localparam logic [7:0] OP_ACTION    = 8'd5;
   localparam logic [7:0] OP_RESET     = 8'd6;

   localparam logic [7:0] HDR_BYTE  = 8'hFF;
   localparam logic [7:0] LEN_SHORT = 8'd2;
   localparam logic [7:0] LEN_BIAS  = 8'd3;

   // Which packet byte the datapath puts on the output register.
   typedef enum logic [2:0] {
      SEL_HEADER,
      SEL_ID,
      SEL_LEN,
      SEL_INSTR,
      SEL_REG,
      SEL_PARAM,
      SEL_CSUM
   } byte_sel_type;

   typedef struct packed {
      logic         absorb;
      logic         capture;
      logic         emit;
      logic         last;
      logic         csum_load;
      logic         rd_step;
      logic         clear;
      byte_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic body;
      logic no_params;
      logic last_param;
   } dp_status_type;

endpackage

// ===== rtl/core/servo_instruction_packet_framer_unit.sv =====
// Top level of the servo instruction packet framer.
// Depends on svpf_pkg, svpf_ctrl and svpf_datapath.
//
// Usage:
// Items come in on the req_ ports and are taken at a clock edge where start is
// high and busy is low. An item with req_has_param set appends req_param_byte
// to a buffer of MAX_PARAMS bytes; bytes beyond that are dropped and flagged on
// rsp_overflow for the whole packet. An item without req_end_of_packet leaves
// busy low, so such items can arrive every cycle.
// The item with req_end_of_packet raises busy and starts the packet burst on
// the rsp_ ports: one byte per cycle with rsp_valid high, the first byte
// from ST_HDR1 through the output register, rsp_tx_last on the checksum
// byte. A packet is 6 bytes for ping, action, reset and unknown codes, and 7
// plus the buffered count for read, write and reg_write. Busy stays high while
// the byte sequencer runs, walking the buffer one entry a cycle.
// The checksum byte appears in the first cycle busy is low again.
// The receiver takes every byte in the cycle it is shown and cannot stall.
// Reset clears the sequencer, count, sum and drop flag; buffer contents are
// left as they are and are only read after being written for the packet.
module servo_instruction_packet_framer_unit #(
   parameter int MAX_PARAMS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_servo_id,
   input  logic [7:0] req_func,
   input  logic [7:0] req_start_reg,
   input  logic [7:0] req_param_byte,
   input  logic       req_has_param,
   input  logic       req_end_of_packet,
   output logic       rsp_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic       rsp_overflow
);
   import svpf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   svpf_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_end_of_packet (req_end_of_packet),
      .status            (status),
      .busy              (busy),
      .cmd               (cmd)
   );

   svpf_datapath #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_servo_id   (req_servo_id),
      .req_func       (req_func),
      .req_start_reg  (req_start_reg),
      .req_param_byte (req_param_byte),
      .req_has_param  (req_has_param),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_tx_last    (rsp_tx_last),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ===== rtl/core/svpf_ctrl.sv =====
// Controller of the servo instruction packet framer: sequences the packet bytes.
// Depends on svpf_pkg; drives the datapath through dp_cmd_type.
module svpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_end_of_packet,
   input  svpf_pkg::dp_status_type status,
   output logic                   busy,
   output svpf_pkg::dp_cmd_type   cmd
);
   import svpf_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_HDR1  = 9'b000000010,
      ST_HDR2  = 9'b000000100,
      ST_ID    = 9'b000001000,
      ST_LEN   = 9'b000010000,
      ST_INSTR = 9'b000100000,
      ST_REG   = 9'b001000000,
      ST_PARAM = 9'b010000000,
      ST_CSUM  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.absorb    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.emit      = 1'b0;
      cmd.last      = 1'b0;
      cmd.csum_load = 1'b0;
      cmd.rd_step   = 1'b0;
      cmd.clear     = 1'b0;
      cmd.sel       = SEL_HEADER;
      case (state_ff)
         ST_IDLE: begin
            cmd.absorb = start;
            if (start && req_end_of_packet) begin
               cmd.capture = 1'b1;
               state_in    = ST_HDR1;
            end
         end
         ST_HDR1: begin
            // The buffer is settled by now, so the checksum is taken here.
            cmd.emit      = 1'b1;
            cmd.sel       = SEL_HEADER;
            cmd.csum_load = 1'b1;
            state_in      = ST_HDR2;
         end
         ST_HDR2: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_HEADER;
            state_in = ST_ID;
         end
         ST_ID: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_ID;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_LEN;
            state_in = ST_INSTR;
         end
         ST_INSTR: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_INSTR;
            state_in = status.body ? ST_REG : ST_CSUM;
         end
         ST_REG: begin
            cmd.emit    = 1'b1;
            cmd.sel     = SEL_REG;
            cmd.rd_step = 1'b1;
            state_in    = status.no_params ? ST_CSUM : ST_PARAM;
         end
         ST_PARAM: begin
            cmd.emit    = 1'b1;
            cmd.sel     = SEL_PARAM;
            cmd.rd_step = 1'b1;
            if (status.last_param) begin
               state_in = ST_CSUM;
            end
         end
         ST_CSUM: begin
            cmd.emit  = 1'b1;
            cmd.sel   = SEL_CSUM;
            cmd.last  = 1'b1;
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/svpf_datapath.sv =====
// Datapath of the servo instruction packet framer: parameter buffer, count, sum,
// checksum and the output register. Depends on svpf_pkg; commanded by svpf_ctrl.
module svpf_datapath #(
   parameter int MAX_PARAMS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_servo_id,
   input  logic [7:0]              req_func,
   input  logic [7:0]              req_start_reg,
   input  logic [7:0]              req_param_byte,
   input  logic                    req_has_param,
   input  svpf_pkg::dp_cmd_type    cmd,
   output svpf_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_tx_last,
   output logic                    rsp_overflow
);
   import svpf_pkg::*;

   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic             dropped_ff, dropped_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       op_ff, op_in;
   logic [7:0]       reg_ff, reg_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       csum_ff, csum_in;
   logic [7:0]       mem_q_ff;
   logic [7:0]       param_mem [MAX_PARAMS];
   logic             wr_en;
   logic             full;
   logic             short_op;
   logic [7:0]       len;
   logic [7:0]       byte_sel;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;

   assign full     = (count_ff == CNT_W'(MAX_PARAMS));
   assign wr_en    = cmd.absorb && req_has_param && !full;
   assign short_op = (op_ff == OP_PING) || (op_ff == OP_ACTION) || (op_ff == OP_RESET);
   assign len      = short_op ? LEN_SHORT : (8'(count_ff) + LEN_BIAS);

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         count_in   = '0;
         sum_in     = '0;
         dropped_in = 1'b0;
      end else if (cmd.absorb && req_has_param) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + req_param_byte;
         end
      end
   end

   always_comb begin
      id_in   = cmd.capture ? req_servo_id : id_ff;
      op_in   = cmd.capture ? req_func : op_ff;
      reg_in  = cmd.capture ? req_start_reg : reg_ff;
      csum_in = cmd.csum_load ? ~(id_ff + len + op_ff + reg_ff + sum_ff) : csum_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.rd_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_HEADER: byte_sel = HDR_BYTE;
         SEL_ID:     byte_sel = id_ff;
         SEL_LEN:    byte_sel = len;
         SEL_INSTR:  byte_sel = op_ff;
         SEL_REG:    byte_sel = reg_ff;
         SEL_PARAM:  byte_sel = mem_q_ff;
         SEL_CSUM:   byte_sel = csum_ff;
         default:    byte_sel = HDR_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      op_ff       <= op_in;
      reg_ff      <= reg_in;
      idx_ff      <= idx_in;
      csum_ff     <= csum_in;
      rsp_byte_ff <= byte_sel;
      rsp_last_ff <= cmd.last;
      rsp_ovf_ff  <= dropped_ff;
   end

   // The read pointer runs one entry ahead so the registered read lines up
   // with the parameter byte slots.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         param_mem[count_ff[IDX_W-1:0]] <= req_param_byte;
      end
      if (idx_ff < CNT_W'(MAX_PARAMS)) begin
         mem_q_ff <= param_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign status.body = (op_ff == OP_READ) || (op_ff == OP_WRITE) ||
                        (op_ff == OP_REG_WRITE);
   assign status.no_params  = (count_ff == '0);
   assign status.last_param = (idx_ff == count_ff);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tx_byte  = rsp_byte_ff;
   assign rsp_tx_last  = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/svpf_checker.sv =====
// Port-level checks of the servo instruction packet framer, bound to the top level.
// Depends on servo_instruction_packet_framer_unit_defines.svh.
`include "servo_instruction_packet_framer_unit_defines.svh"

module svpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_end_of_packet,
   input logic       rsp_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_tx_last
);

   // An end-of-packet transfer starts a burst that opens with the header byte.
   `SVPF_ASSERT(a_eop_busy, start && !busy && req_end_of_packet |=> busy, "eop transfer did not raise busy")
   `SVPF_ASSERT(a_eop_header, start && !busy && req_end_of_packet |-> ##2 (rsp_valid && rsp_tx_byte == 8'hFF), "packet does not open with header byte")
   // A plain parameter transfer produces no output and leaves the block ready.
   `SVPF_ASSERT(a_item_ready, start && !busy && !req_end_of_packet |=> !busy && !rsp_valid, "plain transfer stalled the block or emitted a byte")
   // The checksum byte closes the burst; all earlier bytes come while busy.
   `SVPF_ASSERT(a_last_idle, rsp_valid && rsp_tx_last |-> !busy, "checksum byte shown while busy")
   `SVPF_ASSERT_NEVER(a_body_busy, rsp_valid && !rsp_tx_last && !busy, "packet byte shown while idle")

endmodule

bind servo_instruction_packet_framer_unit svpf_checker u_svpf_checker (.*);

// ===== bench/servo_packet_checker.sv =====
// Checker for the servo instruction packet framer: predicts every packet byte and compares.
// Depends on svpf_pkg; it is instantiated next to the framer by tb_top.
`timescale 1ns / 1ps

module servo_packet_checker #(
   parameter int MAX_PARAMS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [7:0] req_servo_id,
   input  logic [7:0] req_func,
   input  logic [7:0] req_start_reg,
   input  logic [7:0] req_param_byte,
   input  logic       req_has_param,
   input  logic       req_end_of_packet,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_tx_last,
   input  logic       rsp_overflow,
   output int         mismatch_count,
   output int         bytes_pending
);
   import svpf_pkg::*;

   typedef struct {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       overflow;
   } packet_byte_type;

   packet_byte_type tx_expected_q[$];

   logic [7:0] param_bytes [MAX_PARAMS];
   int         param_total;
   logic [7:0] param_sum;
   logic       drop_seen;

   initial begin
      mismatch_count = 0;
      bytes_pending  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic push_tx_byte(input logic [7:0] value, input logic last);
      packet_byte_type pb;
      pb.tx_byte  = value;
      pb.tx_last  = last;
      pb.overflow = drop_seen;
      tx_expected_q.push_back(pb);
   endtask

   // Buffers a parameter byte and, on the closing transfer, builds the whole packet.
   task automatic frame_item(input logic [7:0] servo_id, input logic [7:0] func,
                             input logic [7:0] reg_addr, input logic [7:0] param_byte,
                             input logic has_param, input logic end_of_packet);
      logic [7:0] pkt_len;
      logic [7:0] csum;
      int         i;
      if (has_param) begin
         if (param_total < MAX_PARAMS) begin
            param_bytes[param_total] = param_byte;
            param_total++;
            param_sum = param_sum + param_byte;
         end else begin
            drop_seen = 1'b1;
         end
      end
      if (end_of_packet) begin
         if (func == OP_PING || func == OP_ACTION || func == OP_RESET) begin
            pkt_len = LEN_SHORT;
         end else begin
            pkt_len = 8'(param_total + LEN_BIAS);
         end
         push_tx_byte(HDR_BYTE, 1'b0);
         push_tx_byte(HDR_BYTE, 1'b0);
         push_tx_byte(servo_id, 1'b0);
         push_tx_byte(pkt_len, 1'b0);
         push_tx_byte(func, 1'b0);
         if (func == OP_READ || func == OP_WRITE || func == OP_REG_WRITE) begin
            push_tx_byte(reg_addr, 1'b0);
            for (i = 0; i < param_total; i++) begin
               push_tx_byte(param_bytes[i], 1'b0);
            end
         end
         // The register and the parameter sum enter the checksum even when not sent.
         csum = ~(servo_id + pkt_len + func + reg_addr + param_sum);
         push_tx_byte(csum, 1'b1);
         param_total = 0;
         param_sum   = 8'd0;
         drop_seen   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      packet_byte_type want;
      if (reset) begin
         tx_expected_q.delete();
         param_total = 0;
         param_sum   = 8'd0;
         drop_seen   = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (tx_expected_q.size() == 0) begin
               report_mismatch($sformatf("byte %02h arrived with none expected", rsp_tx_byte));
            end else begin
               want = tx_expected_q.pop_front();
               if (rsp_tx_byte !== want.tx_byte)
                  report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                            rsp_tx_byte, want.tx_byte));
               if (rsp_tx_last !== want.tx_last)
                  report_mismatch($sformatf("tx_last %b, expected %b",
                                            rsp_tx_last, want.tx_last));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("overflow %b, expected %b",
                                            rsp_overflow, want.overflow));
            end
         end
         if (start && !busy) begin
            frame_item(req_servo_id, req_func, req_start_reg, req_param_byte,
                       req_has_param, req_end_of_packet);
         end
      end
      bytes_pending = tx_expected_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the servo instruction packet framer testbench: clock, reset, stimulus and verdict.
// Depends on svpf_pkg, servo_instruction_packet_framer_unit and servo_packet_checker.
`timescale 1ns / 1ps

module tb_top;
   import svpf_pkg::*;

   localparam int MAX_PARAMS   = 16;
   localparam int ITEM_TARGET  = 330;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_servo_id = 8'd0;
   logic [7:0] req_func = 8'd0;
   logic [7:0] req_start_reg = 8'd0;
   logic [7:0] req_param_byte = 8'd0;
   logic       req_has_param = 1'b0;
   logic       req_end_of_packet = 1'b0;
   logic       rsp_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;
   logic       rsp_overflow;

   int mismatch_count;
   int bytes_pending;
   int idle_pct = 0;
   int items_sent = 0;
   int stall_cycles = 0;

   servo_instruction_packet_framer_unit #(.MAX_PARAMS(MAX_PARAMS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_servo_id(req_servo_id), .req_func(req_func), .req_start_reg(req_start_reg),
      .req_param_byte(req_param_byte), .req_has_param(req_has_param),
      .req_end_of_packet(req_end_of_packet),
      .rsp_valid(rsp_valid), .rsp_tx_byte(rsp_tx_byte), .rsp_tx_last(rsp_tx_last),
      .rsp_overflow(rsp_overflow)
   );

   servo_packet_checker #(.MAX_PARAMS(MAX_PARAMS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_servo_id(req_servo_id), .req_func(req_func), .req_start_reg(req_start_reg),
      .req_param_byte(req_param_byte), .req_has_param(req_has_param),
      .req_end_of_packet(req_end_of_packet),
      .rsp_valid(rsp_valid), .rsp_tx_byte(rsp_tx_byte), .rsp_tx_last(rsp_tx_last),
      .rsp_overflow(rsp_overflow),
      .mismatch_count(mismatch_count), .bytes_pending(bytes_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Any cycle with a transfer on either channel restarts the stall count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [7:0] servo_id, input logic [7:0] func,
                            input logic [7:0] reg_addr, input logic [7:0] param_byte,
                            input logic has_param, input logic end_of_packet);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_servo_id      <= servo_id;
      req_func          <= func;
      req_start_reg     <= reg_addr;
      req_param_byte    <= param_byte;
      req_has_param     <= has_param;
      req_end_of_packet <= end_of_packet;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (has_param || end_of_packet) items_sent++;
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      @(negedge clock);
      while (bytes_pending != 0) @(negedge clock);
   endtask

   // A packet with random content; stray items that carry nothing are mixed in.
   task automatic send_random_packet(input logic [7:0] func, input int n_params);
      int i;
      for (i = 0; i < n_params; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), func, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   initial begin
      int         i;
      int         phase;
      int         pick;
      int         n_params;
      logic [7:0] func;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed packets: every instruction, unknown codes, field extremes and a full buffer.
      idle_pct = 19;
      send_item(8'h00, OP_PING, 8'h00, 8'h00, 1'b0, 1'b1);
      send_item(8'hFF, OP_ACTION, 8'hFF, 8'hFF, 1'b0, 1'b1);
      send_item(8'h01, OP_RESET, 8'h80, 8'h55, 1'b1, 1'b1);
      send_item(8'hFE, OP_READ, 8'h24, 8'h02, 1'b1, 1'b1);
      send_item(8'h7F, OP_REG_WRITE, 8'h1E, 8'hAA, 1'b1, 1'b1);
      send_item(8'h10, 8'h00, 8'h05, 8'h00, 1'b0, 1'b1);
      send_item(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
      send_item(8'hA5, 8'hFF, 8'hFF, 8'h01, 1'b1, 1'b1);
      // Sixteen bytes fill the buffer; the one on the closing transfer is dropped.
      for (i = 0; i < MAX_PARAMS; i++)
         send_item(8'h00, 8'h00, 8'h00, (i % 2 == 0) ? 8'hFF : 8'h00, 1'b1, 1'b0);
      send_item(8'hFD, OP_WRITE, 8'h03, 8'hC3, 1'b1, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent * 3 / ITEM_TARGET != phase) begin
            phase = items_sent * 3 / ITEM_TARGET;
            // Let the framer run dry before the idling pattern changes.
            wait_for_drain();
         end
         idle_pct = (phase == 0) ? 19 : (phase == 1) ? 58 : 0;
         pick = $urandom_range(0, 9);
         if (pick < 8)
            func = 8'($urandom_range(1, 6));
         else if (pick == 8)
            func = 8'h00;
         else
            func = 8'($urandom_range(7, 255));
         pick = $urandom_range(0, 9);
         if (pick < 7)
            n_params = $urandom_range(0, 5);
         else if (pick < 9)
            n_params = $urandom_range(6, 13);
         else
            n_params = $urandom_range(14, 20);
         send_random_packet(func, n_params);
      end

      start <= 1'b0;
      @(negedge clock);
      while (bytes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/svpf_pkg.sv
rtl/core/svpf_ctrl.sv
rtl/core/svpf_datapath.sv
rtl/core/servo_instruction_packet_framer_unit.sv
rtl/core/svpf_checker.sv
bench/servo_packet_checker.sv
bench/tb_top.sv
